@@ rtl/tce_pkg.sv @@
// shared constants and types of the tour cost evaluator
package tce_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int WEIGHT_BITS_DEF  = 16;

    localparam int VERTEX_BITS = 6;
    localparam int COUNT_BITS  = 7;
    localparam int COST_BITS   = 22;

    localparam logic [COUNT_BITS-1:0] VERTEX_COUNT_RST = COUNT_BITS'(64);
    localparam logic [COST_BITS-1:0]  COST_MAX         = {COST_BITS{1'b1}};

    typedef enum logic {
        OP_EDGE = 1'b0,
        OP_TOUR = 1'b1
    } t_op;

endpackage

@@ rtl/tce_edge_mem.sv @@
// edge table memory: present bit and weight per ordered pair, cleared after reset
module tce_edge_mem #(
    parameter int ADDR_BITS = 2 * tce_pkg::VERTEX_BITS,
    parameter int DATA_BITS = tce_pkg::WEIGHT_BITS_DEF + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re_a,
    input  logic [ADDR_BITS-1:0] i_raddr_a,
    output logic [DATA_BITS-1:0] o_rdata_a,
    input  logic                 i_re_b,
    input  logic [ADDR_BITS-1:0] i_raddr_b,
    output logic [DATA_BITS-1:0] o_rdata_b,
    output logic                 o_busy
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [ADDR_BITS-1:0] r_clr_addr;
    logic                 r_clr_busy;
    logic [DATA_BITS-1:0] r_rdata_a;
    logic [DATA_BITS-1:0] r_rdata_b;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [DATA_BITS-1:0] wr_data;

    // sweep one entry per cycle after reset, marking every edge absent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {ADDR_BITS{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign wr_en   = r_clr_busy || i_we;
    assign wr_addr = r_clr_busy ? r_clr_addr : i_waddr;
    assign wr_data = r_clr_busy ? '0 : i_wdata;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
    assign o_busy    = r_clr_busy;

endmodule

@@ rtl/tour_cost_evaluator.sv @@
// tour cost evaluator top level: tour tracking, cost accumulation and result register
//
// Takes one transaction per cycle while not stalled, edge writes and tour
// vertices alike. A tour vertex reads the edge from the previous vertex (and,
// for the last vertex, the closing edge back to the first) from a
// two-read-port edge memory with registered read data; the accumulate stage
// then adds the weights and the result register offers the cost of a tour.
// The input stalls only while a finished result waits behind an unread one, and
// after reset while the edge memory is swept clear; vertex_count writes are
// taken during that sweep.
module tour_cost_evaluator #(
    parameter int MAX_VERTICES = tce_pkg::MAX_VERTICES_DEF,
    parameter int WEIGHT_BITS  = tce_pkg::WEIGHT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tce_pkg::COUNT_BITS-1:0]     i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_op,
    input  logic [tce_pkg::VERTEX_BITS-1:0]    i_edge_src,
    input  logic [tce_pkg::VERTEX_BITS-1:0]    i_edge_dst,
    input  logic [15:0]                        i_edge_weight,
    input  logic [tce_pkg::VERTEX_BITS-1:0]    i_vertex,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_tour_valid,
    output logic [tce_pkg::COST_BITS-1:0]      o_tour_cost
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int AW = 2 * VW;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int DW = WEIGHT_BITS + 1;
    localparam int SW = ((WEIGHT_BITS > tce_pkg::COST_BITS) ? WEIGHT_BITS
                                                           : tce_pkg::COST_BITS) + 2;

    // configuration and tour tracking
    logic [tce_pkg::COUNT_BITS-1:0] r_vcount;
    logic [CW-1:0]                  r_pos;
    logic [VW-1:0]                  r_first;
    logic [VW-1:0]                  r_prev;
    logic [MAX_VERTICES-1:0]        r_visited;

    // accumulate stage
    logic                           r_s1_valid;
    logic                           r_s1_need_a;
    logic                           r_s1_need_b;
    logic                           r_s1_bad;
    logic                           r_s1_last;
    logic [tce_pkg::COST_BITS-1:0]  r_cost;
    logic                           r_broken;

    // result register
    logic                           r_out_valid;
    logic                           r_out_tour_valid;
    logic [tce_pkg::COST_BITS-1:0]  r_out_cost;

    logic                           mem_busy;
    logic [DW-1:0]                  rdata_a;
    logic [DW-1:0]                  rdata_b;
    logic                           in_acc;
    logic                           edge_acc;
    logic                           tour_acc;
    logic                           src_ok;
    logic                           dst_ok;
    logic                           v_ok;
    logic [VW-1:0]                  v_idx;
    logic [VW-1:0]                  first_sel;
    logic [CW-1:0]                  eff_count;
    logic [CW-1:0]                  pos_next;
    logic                           is_first;
    logic                           is_last;
    logic                           dup;
    logic                           s1_hold;
    logic                           s1_fire;
    logic                           pres_a;
    logic                           pres_b;
    logic [SW-1:0]                  sum;
    logic [tce_pkg::COST_BITS-1:0]  sum_sat;
    logic                           brk;

    always_comb begin
        priority if (r_vcount == '0) begin
            eff_count = CW'(1);
        end else if (32'(r_vcount) > MAX_VERTICES) begin
            eff_count = CW'(MAX_VERTICES);
        end else begin
            eff_count = CW'(r_vcount);
        end
    end

    // a finished tour cannot move on while the result register is still waiting
    assign s1_hold  = r_s1_valid && r_s1_last && r_out_valid && i_stall;
    assign s1_fire  = r_s1_valid && !s1_hold;
    assign o_stall  = mem_busy || s1_hold;

    assign in_acc   = i_valid && !o_stall;
    assign edge_acc = in_acc && (tce_pkg::t_op'(i_op) == tce_pkg::OP_EDGE);
    assign tour_acc = in_acc && (tce_pkg::t_op'(i_op) == tce_pkg::OP_TOUR);

    assign src_ok    = 32'(i_edge_src) < MAX_VERTICES;
    assign dst_ok    = 32'(i_edge_dst) < MAX_VERTICES;
    assign v_ok      = 32'(i_vertex) < MAX_VERTICES;
    assign v_idx     = VW'(i_vertex);
    assign is_first  = r_pos == '0;
    assign pos_next  = r_pos + 1'b1;
    assign is_last   = pos_next == eff_count;
    assign dup       = v_ok && r_visited[v_idx];
    assign first_sel = is_first ? v_idx : r_first;

    tce_edge_mem #(
        .ADDR_BITS (AW),
        .DATA_BITS (DW)
    ) u_edge_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (edge_acc && src_ok && dst_ok),
        .i_waddr   ({VW'(i_edge_src), VW'(i_edge_dst)}),
        .i_wdata   ({1'b1, WEIGHT_BITS'(i_edge_weight)}),
        .i_re_a    (tour_acc && !is_first),
        .i_raddr_a ({r_prev, v_idx}),
        .o_rdata_a (rdata_a),
        .i_re_b    (tour_acc && is_last),
        .i_raddr_b ({v_idx, first_sel}),
        .o_rdata_b (rdata_b),
        .o_busy    (mem_busy)
    );

    assign pres_a = rdata_a[DW-1];
    assign pres_b = rdata_b[DW-1];

    always_comb begin
        sum = SW'(r_cost)
            + ((r_s1_need_a && pres_a) ? SW'(rdata_a[WEIGHT_BITS-1:0]) : '0)
            + ((r_s1_need_b && pres_b) ? SW'(rdata_b[WEIGHT_BITS-1:0]) : '0);
        sum_sat = (sum > SW'(tce_pkg::COST_MAX)) ? tce_pkg::COST_MAX
                                                 : sum[tce_pkg::COST_BITS-1:0];
        brk = r_broken || r_s1_bad || (r_s1_need_a && !pres_a)
            || (r_s1_need_b && !pres_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount    <= tce_pkg::VERTEX_COUNT_RST;
            r_pos       <= '0;
            r_first     <= '0;
            r_prev      <= '0;
            r_visited   <= '0;
            r_s1_valid  <= 1'b0;
            r_cost      <= '0;
            r_broken    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!i_cfg_we && s1_fire && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            // tour tracking
            if (i_cfg_we) begin
                r_vcount  <= i_cfg_data;
                r_pos     <= '0;
                r_first   <= '0;
                r_prev    <= '0;
                r_visited <= '0;
            end else if (tour_acc) begin
                if (is_last) begin
                    r_pos     <= '0;
                    r_first   <= '0;
                    r_prev    <= '0;
                    r_visited <= '0;
                end else begin
                    r_pos  <= pos_next;
                    r_prev <= v_idx;
                    if (is_first) begin
                        r_first <= v_idx;
                    end
                    if (v_ok) begin
                        r_visited[v_idx] <= 1'b1;
                    end
                end
            end

            // accumulate stage
            if (tour_acc) begin
                r_s1_valid  <= 1'b1;
                r_s1_need_a <= !is_first;
                r_s1_need_b <= is_last;
                r_s1_bad    <= !v_ok || dup;
                r_s1_last   <= is_last;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_cost   <= '0;
                r_broken <= 1'b0;
            end else if (s1_fire) begin
                if (r_s1_last) begin
                    r_cost           <= '0;
                    r_broken         <= 1'b0;
                    r_out_tour_valid <= !brk;
                    r_out_cost       <= brk ? '0 : sum_sat;
                end else begin
                    r_cost   <= sum_sat;
                    r_broken <= brk;
                end
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_tour_valid = r_out_tour_valid;
    assign o_tour_cost  = r_out_cost;

`ifndef SYNTHESIS
    // a finished tour never overwrites a result that is still waiting
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_last) |-> (!r_out_valid || !i_stall))
        else $error("tour result dropped while output stalled");

    // the tour position stays inside the effective vertex count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < eff_count)
        else $error("tour position beyond vertex count");

    // every visited mark belongs to a vertex already taken in this tour
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_visited) <= 32'(r_pos))
        else $error("visited map out of step with tour position");

    // a rejected tour reports zero cost
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_tour_valid) |-> (o_tour_cost == '0))
        else $error("invalid tour with nonzero cost");
`endif

endmodule
